### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// immediate-free concurrent checks, removed when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oms assertion failed");

// next-cycle implication
`define OMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oms assertion failed");

`else

`define OMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/oms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oms_pkg
// shared widths, codes and types of the order statistic multiset
// ----------------------------------------------------------------------------
package oms_pkg;

    // field widths
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // default number of cells
    localparam int CAPACITY_DEF = 64;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // update command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } cell_op_t;

endpackage

### rtl/oms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oms_cell
// one slot of the sorted row: compares against the probe and shifts left or
// right with its neighbours on insert and erase
// ----------------------------------------------------------------------------
module oms_cell (
    input  logic                                clk,
    input  logic signed [oms_pkg::VALUE_W-1:0]  probe,
    input  logic signed [oms_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [oms_pkg::VALUE_W-1:0]  right_value,
    input  logic                                left_gt,
    input  logic                                occupied,
    input  logic                                sel,
    input  oms_pkg::cell_op_t                   op,
    output logic signed [oms_pkg::VALUE_W-1:0]  value_q,
    output logic                                gt,
    output logic                                lt,
    output logic                                le,
    output logic [oms_pkg::VALUE_W-1:0]         kth_leaf
);

    logic signed [oms_pkg::VALUE_W-1:0] value_reg;
    logic signed [oms_pkg::VALUE_W-1:0] value_next;

    // local comparisons, only meaningful for an occupied slot
    assign gt = occupied && (value_reg > probe);
    assign lt = occupied && (value_reg < probe);
    assign le = occupied && (value_reg <= probe);

    assign value_q  = value_reg;
    assign kth_leaf = sel ? value_reg : '0;

    // shift right past the insertion point, shift left from the erased slot
    always_comb
    begin
        value_next = value_reg;
        priority if (op.ins)
        begin
            if (left_gt)
                value_next = left_value;
            else if (!occupied || gt)
                value_next = probe;
        end
        else if (op.del)
        begin
            if (!occupied || !lt)
                value_next = right_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

### rtl/oms_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oms_tree
// registered binary adder tree, one register level per addition level
// ----------------------------------------------------------------------------
module oms_tree #(
    parameter int N = 2,
    parameter int W = 8
) (
    input  logic         clk,
    input  logic [W-1:0] leaf [N],
    output logic [W-1:0] sum
);

    localparam int LEVELS = $clog2(N);
    localparam int P      = 1 << LEVELS;

    logic [W-1:0] pad [P];
    logic [W-1:0] lvl_reg [LEVELS][P];

    // pad the leaves up to a power of two
    for (genvar j = 0; j < P; j++)
    begin : g_pad
        if (j < N)
        begin : g_leaf
            assign pad[j] = leaf[j];
        end
        else
        begin : g_zero
            assign pad[j] = '0;
        end
    end

    // one registered addition level after another
    for (genvar l = 0; l < LEVELS; l++)
    begin : g_lvl
        for (genvar j = 0; j < P; j++)
        begin : g_node
            if (j < (P >> (l + 1)))
            begin : g_add
                if (l == 0)
                begin : g_first
                    always_ff @(posedge clk)
                    begin
                        lvl_reg[l][j] <= pad[2*j] + pad[2*j+1];
                    end
                end
                else
                begin : g_next
                    always_ff @(posedge clk)
                    begin
                        lvl_reg[l][j] <= lvl_reg[l-1][2*j] + lvl_reg[l-1][2*j+1];
                    end
                end
            end
            else
            begin : g_unused
                assign lvl_reg[l][j] = '0;
            end
        end
    end

    assign sum = lvl_reg[LEVELS-1][0];

endmodule

### rtl/order_statistic_multiset_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset_top
// sorted multiset of signed values with rank counts and k-th smallest lookup
// ----------------------------------------------------------------------------
// The values sit in a row of CAPACITY cells kept in ascending order; insert
// and erase shift the row by one place in the apply step. Rank counts and the
// k-th value come from registered adder trees over all cells, and the block
// takes one item at a time. A query runs the trees once and an insert shifts
// the row and then runs them; an erase runs the trees once before the shift
// to find a copy and once after it. A finished result waits in the output
// register, so the next item is taken while it is still unread.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module order_statistic_multiset_top #(
    parameter int CAPACITY = oms_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [oms_pkg::ACTION_W-1:0]         action,
    input  logic signed [oms_pkg::VALUE_W-1:0]   value,
    input  logic [oms_pkg::INDEX_W-1:0]          index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [oms_pkg::STATUS_W-1:0]         status,
    output logic [oms_pkg::COUNT_W-1:0]          less_count,
    output logic [oms_pkg::COUNT_W-1:0]          less_equal_count,
    output logic [oms_pkg::COUNT_W-1:0]          greater_count,
    output logic [oms_pkg::COUNT_W-1:0]          greater_equal_count,
    output logic signed [oms_pkg::VALUE_W-1:0]   kth_value,
    output logic                                 kth_found,
    output logic [oms_pkg::COUNT_W-1:0]          element_count
);

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TREE_LAT = $clog2(CAPACITY);
    localparam int WAIT_W   = $clog2(TREE_LAT) + 1;
    localparam int OUT_CW   = oms_pkg::COUNT_W;
    localparam int VW       = oms_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_APPLY,
        S_POST,
        S_DONE
    } state_t;

    state_t                          state_reg;
    logic [WAIT_W-1:0]               wait_reg;
    logic [oms_pkg::ACTION_W-1:0]    act_reg;
    logic signed [VW-1:0]            probe_reg;
    logic [oms_pkg::INDEX_W-1:0]     index_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [oms_pkg::STATUS_W-1:0]    status_reg;
    logic [oms_pkg::STATUS_W-1:0]    result_status_reg;
    logic                            out_valid_reg;
    logic [OUT_CW-1:0]               less_reg;
    logic [OUT_CW-1:0]               less_equal_reg;
    logic [OUT_CW-1:0]               greater_reg;
    logic [OUT_CW-1:0]               greater_equal_reg;
    logic signed [VW-1:0]            kth_value_reg;
    logic                            kth_found_reg;
    logic [OUT_CW-1:0]               element_reg;

    logic signed [VW-1:0] cell_val  [CAPACITY];
    logic                 cell_gt   [CAPACITY];
    logic                 cell_lt   [CAPACITY];
    logic                 cell_le   [CAPACITY];
    logic [CNT_W-1:0]     lt_leaf   [CAPACITY];
    logic [CNT_W-1:0]     le_leaf   [CAPACITY];
    logic [VW-1:0]        kth_leaf  [CAPACITY];

    logic [CNT_W-1:0]     lt_sum;
    logic [CNT_W-1:0]     le_sum;
    logic [VW-1:0]        kth_sum;
    logic                 full;
    logic                 found;
    logic                 kth_hit;
    oms_pkg::cell_op_t    op;

    // update decision, taken in the shift cycle only
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign found   = (lt_sum != le_sum);
    assign kth_hit = (32'(index_reg) < 32'(count_reg));
    assign op.ins  = (state_reg == S_APPLY) && (act_reg == oms_pkg::ACT_INSERT) && !full;
    assign op.del  = (state_reg == S_APPLY) && (act_reg == oms_pkg::ACT_ERASE) && found;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VW-1:0] left_value;
        logic signed [VW-1:0] right_value;
        logic                 left_gt;
        logic                 occupied;
        logic                 sel;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_inner
            assign left_value = cell_val[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_val[i];
        end
        else
        begin : g_mid
            assign right_value = cell_val[i+1];
        end

        assign occupied = (CNT_W'(i) < count_reg);
        assign sel      = (32'(index_reg) == i);

        oms_cell u_cell (
            .clk         (clk),
            .probe       (probe_reg),
            .left_value  (left_value),
            .right_value (right_value),
            .left_gt     (left_gt),
            .occupied    (occupied),
            .sel         (sel),
            .op          (op),
            .value_q     (cell_val[i]),
            .gt          (cell_gt[i]),
            .lt          (cell_lt[i]),
            .le          (cell_le[i]),
            .kth_leaf    (kth_leaf[i])
        );

        assign lt_leaf[i] = CNT_W'(cell_lt[i]);
        assign le_leaf[i] = CNT_W'(cell_le[i]);
    end

    // rank counts and k-th value
    oms_tree #(.N(CAPACITY), .W(CNT_W)) u_lt_tree (
        .clk  (clk),
        .leaf (lt_leaf),
        .sum  (lt_sum)
    );

    oms_tree #(.N(CAPACITY), .W(CNT_W)) u_le_tree (
        .clk  (clk),
        .leaf (le_leaf),
        .sum  (le_sum)
    );

    oms_tree #(.N(CAPACITY), .W(VW)) u_kth_tree (
        .clk  (clk),
        .leaf (kth_leaf),
        .sum  (kth_sum)
    );

    assign in_ready = (state_reg == S_IDLE);

    // sequencer, count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            wait_reg          <= '0;
            act_reg           <= oms_pkg::ACT_QUERY;
            probe_reg         <= '0;
            index_reg         <= '0;
            count_reg         <= '0;
            status_reg        <= oms_pkg::ST_OK;
            result_status_reg <= oms_pkg::ST_OK;
            out_valid_reg     <= 1'b0;
            less_reg          <= '0;
            less_equal_reg    <= '0;
            greater_reg       <= '0;
            greater_equal_reg <= '0;
            kth_value_reg     <= '0;
            kth_found_reg     <= 1'b0;
            element_reg       <= '0;
        end
        else
        begin
            // result taken; a finishing item reloads it below instead
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg    <= action;
                        probe_reg  <= value;
                        index_reg  <= index;
                        status_reg <= oms_pkg::ST_OK;
                        wait_reg   <= '0;
                        priority if (action == oms_pkg::ACT_INSERT)
                            state_reg <= S_APPLY;
                        else if (action == oms_pkg::ACT_ERASE)
                            state_reg <= S_PRE;
                        else
                            state_reg <= S_POST;
                    end
                end

                S_PRE:
                begin
                    if (wait_reg == WAIT_W'(TREE_LAT - 1))
                        state_reg <= S_APPLY;
                    else
                        wait_reg <= wait_reg + 1'b1;
                end

                S_APPLY:
                begin
                    if (op.ins)
                        count_reg <= count_reg + 1'b1;
                    else if (op.del)
                        count_reg <= count_reg - 1'b1;

                    if (act_reg == oms_pkg::ACT_INSERT && full)
                        status_reg <= oms_pkg::ST_FULL;
                    else if (act_reg == oms_pkg::ACT_ERASE && !found)
                        status_reg <= oms_pkg::ST_MISSING;

                    wait_reg  <= '0;
                    state_reg <= S_POST;
                end

                S_POST:
                begin
                    if (wait_reg == WAIT_W'(TREE_LAT - 1))
                        state_reg <= S_DONE;
                    else
                        wait_reg <= wait_reg + 1'b1;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg     <= 1'b1;
                        result_status_reg <= status_reg;
                        less_reg          <= OUT_CW'(lt_sum);
                        less_equal_reg    <= OUT_CW'(le_sum);
                        greater_reg       <= OUT_CW'(count_reg - le_sum);
                        greater_equal_reg <= OUT_CW'(count_reg - lt_sum);
                        kth_found_reg     <= kth_hit;
                        kth_value_reg     <= kth_hit ? $signed(kth_sum) : '0;
                        element_reg       <= OUT_CW'(count_reg);
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid           = out_valid_reg;
    assign status              = result_status_reg;
    assign less_count          = less_reg;
    assign less_equal_count    = less_equal_reg;
    assign greater_count       = greater_reg;
    assign greater_equal_count = greater_equal_reg;
    assign kth_value           = kth_value_reg;
    assign kth_found           = kth_found_reg;
    assign element_count       = element_reg;

    // checks
    `OMS_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `OMS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `OMS_ASSERT_NEXT(a_full_refused, clk, rst_n, state_reg == S_APPLY && act_reg == oms_pkg::ACT_INSERT && full, status_reg == oms_pkg::ST_FULL && $stable(count_reg))
    `OMS_ASSERT_NEXT(a_erase_shrinks, clk, rst_n, op.del, count_reg == $past(count_reg) - 1'b1)
    `OMS_ASSERT_IMPL(a_no_dual_op, clk, rst_n, 1'b1, !(op.ins && op.del))

endmodule
